### rtl/obbsat_pkg.sv
`timescale 1ns / 1ps

package obbsat_pkg;

   // default geometry
   localparam int POS_BITS_DEF       = 24;
   localparam int TRIG_FRAC_BITS_DEF = 14;

   // fixed field widths
   localparam int TRIG_BITS = 16;
   localparam int SIZE_BITS = 16;

   // trig products and weights: |c*c' + s*s'| <= 2^31
   localparam int TPROD_BITS  = 2 * TRIG_BITS;
   localparam int WEIGHT_BITS = 2 * TRIG_BITS;

   // radius: three products of size by weight
   localparam int RPROD_BITS = SIZE_BITS + WEIGHT_BITS;
   localparam int RAD_BITS   = RPROD_BITS + 2;

   // terms per axis radius, number of axes, distance products
   localparam int TERMS     = 3;
   localparam int AXES      = 4;
   localparam int DPRODS    = 2 * AXES;

   // one half-size and the axis weight that scales it
   typedef struct packed {
      logic [SIZE_BITS-1:0]   size;
      logic [WEIGHT_BITS-1:0] weight;
   } term_type;

endpackage

### rtl/obbsat_axis.sv
`timescale 1ns / 1ps

// One separating-axis check: distance magnitude against the summed radius.
// One register stage inside; the overlap flag leaves combinationally from it.
module obbsat_axis #(
   parameter int POS_BITS       = obbsat_pkg::POS_BITS_DEF,
   parameter int TRIG_FRAC_BITS = obbsat_pkg::TRIG_FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic signed [POS_BITS+16:0]           dist_x_prod,
   input  logic signed [POS_BITS+16:0]           dist_y_prod,
   input  logic                                  negate_y,
   input  obbsat_pkg::term_type                  terms [obbsat_pkg::TERMS],
   output logic                                  overlap
);

   localparam int PROD_BITS = POS_BITS + 17;
   localparam int DIST_BITS = PROD_BITS + 1;
   localparam int RAD_BITS  = obbsat_pkg::RAD_BITS;
   localparam int CMP_BITS  = (DIST_BITS > RAD_BITS) ? DIST_BITS : RAD_BITS;

   logic signed [DIST_BITS-1:0]          dist_sum;
   logic        [DIST_BITS-1:0]          dist_abs_in;
   logic        [DIST_BITS-1:0]          dist_abs_ff;
   logic [obbsat_pkg::RPROD_BITS-1:0]    rad_prod_in [obbsat_pkg::TERMS];
   logic [obbsat_pkg::RPROD_BITS-1:0]    rad_prod_ff [obbsat_pkg::TERMS];
   logic [RAD_BITS-1:0]                  rad_sum;
   logic [RAD_BITS-1:0]                  reach;

   // projected center distance, magnitude
   always_comb begin
      if (negate_y) begin
         dist_sum = DIST_BITS'(dist_x_prod) - DIST_BITS'(dist_y_prod);
      end else begin
         dist_sum = DIST_BITS'(dist_x_prod) + DIST_BITS'(dist_y_prod);
      end
      if (dist_sum[DIST_BITS-1]) begin
         dist_abs_in = DIST_BITS'(-dist_sum);
      end else begin
         dist_abs_in = DIST_BITS'(dist_sum);
      end
   end

   // radius terms: half size times axis weight
   always_comb begin
      for (int i = 0; i < obbsat_pkg::TERMS; i++) begin
         rad_prod_in[i] = obbsat_pkg::RPROD_BITS'(terms[i].size) *
                          obbsat_pkg::RPROD_BITS'(terms[i].weight);
      end
   end

   always_ff @(posedge clock) begin
      dist_abs_ff <= dist_abs_in;
      rad_prod_ff <= rad_prod_in;
   end

   // summed reach, rescaled by the trig fraction, against the distance
   assign rad_sum = RAD_BITS'(rad_prod_ff[0]) + RAD_BITS'(rad_prod_ff[1]) +
                    RAD_BITS'(rad_prod_ff[2]);
   assign reach   = rad_sum >> TRIG_FRAC_BITS;
   assign overlap = CMP_BITS'(dist_abs_ff) <= CMP_BITS'(reach);

endmodule

### rtl/oriented_box_overlap_test_core.sv
`timescale 1ns / 1ps
// A word accepted on start passes the stage 1, stage 2, axis and result registers;
// its rsp_valid strobe is then held for one cycle.
// Throughput: one box pair per cycle through four register stages; busy is
// low except during reset, and the receiver cannot stall.
// Reset (synchronous, active high) clears the valid bits; no data is kept.
module oriented_box_overlap_test_core #(
   parameter int POS_BITS       = obbsat_pkg::POS_BITS_DEF,
   parameter int TRIG_FRAC_BITS = obbsat_pkg::TRIG_FRAC_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [POS_BITS-1:0]              req_a_pos_x,
   input  logic signed [POS_BITS-1:0]              req_a_pos_y,
   input  logic signed [obbsat_pkg::TRIG_BITS-1:0] req_a_cosine,
   input  logic signed [obbsat_pkg::TRIG_BITS-1:0] req_a_sine,
   input  logic        [obbsat_pkg::SIZE_BITS-1:0] req_a_half_len,
   input  logic        [obbsat_pkg::SIZE_BITS-1:0] req_a_half_wid,
   input  logic signed [POS_BITS-1:0]              req_b_pos_x,
   input  logic signed [POS_BITS-1:0]              req_b_pos_y,
   input  logic signed [obbsat_pkg::TRIG_BITS-1:0] req_b_cosine,
   input  logic signed [obbsat_pkg::TRIG_BITS-1:0] req_b_sine,
   input  logic        [obbsat_pkg::SIZE_BITS-1:0] req_b_half_len,
   input  logic        [obbsat_pkg::SIZE_BITS-1:0] req_b_half_wid,
   output logic                                    rsp_valid,
   output logic                                    rsp_collide
);

   localparam int DIFF_BITS  = POS_BITS + 1;
   localparam int PROD_BITS  = POS_BITS + 17;
   localparam int TB         = obbsat_pkg::TRIG_BITS;
   localparam int SB         = obbsat_pkg::SIZE_BITS;
   localparam int TP         = obbsat_pkg::TPROD_BITS;
   localparam int WB         = obbsat_pkg::WEIGHT_BITS;
   localparam int AXES       = obbsat_pkg::AXES;
   localparam int TERMS      = obbsat_pkg::TERMS;

   // trig product order
   localparam int TP_CACA = 0;
   localparam int TP_SASA = 1;
   localparam int TP_CBCB = 2;
   localparam int TP_SBSB = 3;
   localparam int TP_CACB = 4;
   localparam int TP_SASB = 5;
   localparam int TP_SBCA = 6;
   localparam int TP_CBSA = 7;
   localparam int TP_COUNT = 8;

   logic word_accept;

   // stage 1 registers
   logic                        s1_valid_ff;
   logic signed [DIFF_BITS-1:0] dx_in, dx_ff;
   logic signed [DIFF_BITS-1:0] dy_in, dy_ff;
   logic signed [TP-1:0]        tprod_in [TP_COUNT];
   logic signed [TP-1:0]        tprod_ff [TP_COUNT];
   logic signed [TB-1:0]        ca_ff, sa_ff, cb_ff, sb_ff;
   logic        [SB-1:0]        s1_hla_ff, s1_hwa_ff, s1_hlb_ff, s1_hwb_ff;

   // stage 2 registers
   logic                        s2_valid_ff;
   logic        [WB-1:0]        norm_a_in, norm_a_ff;
   logic        [WB-1:0]        norm_b_in, norm_b_ff;
   logic        [WB-1:0]        dot_p_in, dot_p_ff;
   logic        [WB-1:0]        dot_q_in, dot_q_ff;
   logic signed [TP:0]          p_sum, q_sum;
   logic signed [PROD_BITS-1:0] dprod_in [obbsat_pkg::DPRODS];
   logic signed [PROD_BITS-1:0] dprod_ff [obbsat_pkg::DPRODS];
   logic        [SB-1:0]        s2_hla_ff, s2_hwa_ff, s2_hlb_ff, s2_hwb_ff;

   // stage 3 and output
   logic                        s3_valid_ff;
   obbsat_pkg::term_type        axis_terms [AXES][TERMS];
   logic [AXES-1:0]             axis_overlap;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_collide_ff, rsp_collide_in;

   assign busy        = reset;
   assign word_accept = start & ~busy;

   // stage 1: center differences and trig products
   always_comb begin
      dx_in = DIFF_BITS'(req_b_pos_x) - DIFF_BITS'(req_a_pos_x);
      dy_in = DIFF_BITS'(req_b_pos_y) - DIFF_BITS'(req_a_pos_y);
      tprod_in[TP_CACA] = TP'(req_a_cosine) * TP'(req_a_cosine);
      tprod_in[TP_SASA] = TP'(req_a_sine)   * TP'(req_a_sine);
      tprod_in[TP_CBCB] = TP'(req_b_cosine) * TP'(req_b_cosine);
      tprod_in[TP_SBSB] = TP'(req_b_sine)   * TP'(req_b_sine);
      tprod_in[TP_CACB] = TP'(req_a_cosine) * TP'(req_b_cosine);
      tprod_in[TP_SASB] = TP'(req_a_sine)   * TP'(req_b_sine);
      tprod_in[TP_SBCA] = TP'(req_b_sine)   * TP'(req_a_cosine);
      tprod_in[TP_CBSA] = TP'(req_b_cosine) * TP'(req_a_sine);
   end

   always_ff @(posedge clock) begin
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      tprod_ff  <= tprod_in;
      ca_ff     <= req_a_cosine;
      sa_ff     <= req_a_sine;
      cb_ff     <= req_b_cosine;
      sb_ff     <= req_b_sine;
      s1_hla_ff <= req_a_half_len;
      s1_hwa_ff <= req_a_half_wid;
      s1_hlb_ff <= req_b_half_len;
      s1_hwb_ff <= req_b_half_wid;
   end

   // stage 2: axis weights (norms, |p|, |q|) and distance products
   always_comb begin
      norm_a_in = WB'(tprod_ff[TP_CACA]) + WB'(tprod_ff[TP_SASA]);
      norm_b_in = WB'(tprod_ff[TP_CBCB]) + WB'(tprod_ff[TP_SBSB]);
      p_sum = (TP+1)'(tprod_ff[TP_CACB]) + (TP+1)'(tprod_ff[TP_SASB]);
      q_sum = (TP+1)'(tprod_ff[TP_SBCA]) - (TP+1)'(tprod_ff[TP_CBSA]);
      dot_p_in = p_sum[TP] ? WB'(-p_sum) : WB'(p_sum);
      dot_q_in = q_sum[TP] ? WB'(-q_sum) : WB'(q_sum);
      // per axis: x product, y product (uA, vA, uB, vB)
      dprod_in[0] = PROD_BITS'(dx_ff) * PROD_BITS'(ca_ff);
      dprod_in[1] = PROD_BITS'(dy_ff) * PROD_BITS'(sa_ff);
      dprod_in[2] = PROD_BITS'(dx_ff) * PROD_BITS'(sa_ff);
      dprod_in[3] = PROD_BITS'(dy_ff) * PROD_BITS'(ca_ff);
      dprod_in[4] = PROD_BITS'(dx_ff) * PROD_BITS'(cb_ff);
      dprod_in[5] = PROD_BITS'(dy_ff) * PROD_BITS'(sb_ff);
      dprod_in[6] = PROD_BITS'(dx_ff) * PROD_BITS'(sb_ff);
      dprod_in[7] = PROD_BITS'(dy_ff) * PROD_BITS'(cb_ff);
   end

   always_ff @(posedge clock) begin
      norm_a_ff <= norm_a_in;
      norm_b_ff <= norm_b_in;
      dot_p_ff  <= dot_p_in;
      dot_q_ff  <= dot_q_in;
      dprod_ff  <= dprod_in;
      s2_hla_ff <= s1_hla_ff;
      s2_hwa_ff <= s1_hwa_ff;
      s2_hlb_ff <= s1_hlb_ff;
      s2_hwb_ff <= s1_hwb_ff;
   end

   // radius terms per axis; the cross term of a box on its own axes is zero
   always_comb begin
      axis_terms[0][0] = '{size: s2_hla_ff, weight: norm_a_ff};
      axis_terms[0][1] = '{size: s2_hlb_ff, weight: dot_p_ff};
      axis_terms[0][2] = '{size: s2_hwb_ff, weight: dot_q_ff};
      axis_terms[1][0] = '{size: s2_hwa_ff, weight: norm_a_ff};
      axis_terms[1][1] = '{size: s2_hlb_ff, weight: dot_q_ff};
      axis_terms[1][2] = '{size: s2_hwb_ff, weight: dot_p_ff};
      axis_terms[2][0] = '{size: s2_hla_ff, weight: dot_p_ff};
      axis_terms[2][1] = '{size: s2_hwa_ff, weight: dot_q_ff};
      axis_terms[2][2] = '{size: s2_hlb_ff, weight: norm_b_ff};
      axis_terms[3][0] = '{size: s2_hla_ff, weight: dot_q_ff};
      axis_terms[3][1] = '{size: s2_hwa_ff, weight: dot_p_ff};
      axis_terms[3][2] = '{size: s2_hwb_ff, weight: norm_b_ff};
   end

   // stage 3: one checker per axis; heading axes subtract the y term
   for (genvar g = 0; g < AXES; g++) begin : g_axis
      obbsat_axis #(
         .POS_BITS       (POS_BITS),
         .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
      ) u_axis (
         .clock       (clock),
         .dist_x_prod (dprod_ff[2*g]),
         .dist_y_prod (dprod_ff[2*g+1]),
         .negate_y    ((g % 2) == 0),
         .terms       (axis_terms[g]),
         .overlap     (axis_overlap[g])
      );
   end

   // result word
   assign rsp_valid_in   = s3_valid_ff;
   assign rsp_collide_in = &axis_overlap;

   always_ff @(posedge clock) begin
      rsp_collide_ff <= rsp_collide_in;
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= word_accept;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_collide = rsp_collide_ff;

endmodule
